// ===== rtl/hdlc_crc16_frame_codec_defines.svh =====
// ----------------------------------------------------------------------------
// hdlc_crc16_frame_codec_defines
// assertion macros shared by the codec modules, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef HDLC_CRC16_FRAME_CODEC_DEFINES_SVH
`define HDLC_CRC16_FRAME_CODEC_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off during reset
`define HCFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define HCFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define HCFC_ASSERT_IMP(lbl, ante, cons, msg)
`define HCFC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/hcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcfc_pkg
// types and constants of the hdlc crc-16 frame codec
// ----------------------------------------------------------------------------
package hcfc_pkg;

	// line bytes
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	// crc-16 polynomial, init zero, msb first
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// register map: paddr[2] selects the register word
	localparam logic REG_DIRECTION = 1'b0;
	localparam int   PADDR_W       = 3;

	// direction codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// segments of one job, in emission order
	localparam int NUM_SEGS = 5;

	typedef enum logic [2:0] {
		PH_PRE    = 3'd0,
		PH_BODY   = 3'd1,
		PH_CRC_LO = 3'd2,
		PH_CRC_HI = 3'd3,
		PH_FLAG   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_item_t;

	// one classified input: the bytes it causes, as optional segments
	typedef struct packed {
		logic        pre_valid;   // leading flag (encode) or stale escape (decode)
		logic [7:0]  pre_byte;
		logic        body_valid;
		logic        body_esc;    // body byte is stuffed on the line if it is a flag or escape
		logic [7:0]  body;
		logic        trailer;     // crc low, crc high and closing flag follow
		logic [15:0] crc;
		logic        frame_end;   // set on the final byte of the job
	} job_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/hcfc_front.sv =====
// ----------------------------------------------------------------------------
// hcfc_front
// accepts input beats, runs the crc and escape state, classifies into jobs
// ----------------------------------------------------------------------------
`include "hdlc_crc16_frame_codec_defines.svh"

module hcfc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                direction,
	input  logic                in_valid,
	output logic                in_stall,
	input  hcfc_pkg::in_item_t  in_data,
	input  hcfc_pkg::q_status_t q_status,
	output logic                push,
	output hcfc_pkg::job_t      push_job
);
	import hcfc_pkg::*;

	logic [15:0] crc_q;
	logic        esc_pend_q;
	logic        accept;
	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic        pend;
	logic        new_pend;
	logic        handled;
	job_t        job;

	// one byte of crc, eight shift steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	// frame start clears crc and held escape
	assign crc_base = in_data.first_byte ? 16'h0000 : crc_q;
	assign pend     = in_data.first_byte ? 1'b0 : esc_pend_q;
	assign crc_next = crc16_byte(crc_base, in_data.data_byte);

	// classify the beat into a job
	always_comb begin
		job          = '0;
		new_pend     = 1'b0;
		handled      = 1'b0;
		job.body     = in_data.data_byte;
		job.pre_byte = FLAG_BYTE;
		if (direction == DIR_ENCODE) begin
			job.pre_valid  = in_data.first_byte;
			job.body_valid = 1'b1;
			job.body_esc   = 1'b1;
			job.trailer    = in_data.last_byte;
			job.crc        = crc_next;
			job.frame_end  = in_data.last_byte;
		end else begin
			job.pre_byte  = ESC_BYTE;
			job.frame_end = in_data.last_byte;
			if (pend) begin
				if (in_data.data_byte == ESC_FLAG) begin
					job.body       = FLAG_BYTE;
					job.body_valid = 1'b1;
					handled        = 1'b1;
				end else if (in_data.data_byte == ESC_ESC) begin
					job.body       = ESC_BYTE;
					job.body_valid = 1'b1;
					handled        = 1'b1;
				end else begin
					job.pre_valid = 1'b1;
				end
			end
			if (!handled) begin
				if (in_data.data_byte == ESC_BYTE && !in_data.last_byte) begin
					new_pend = 1'b1;
				end else begin
					job.body_valid = 1'b1;
				end
			end
		end
	end

	assign push_job = job;
	assign push     = accept && (job.pre_valid || job.body_valid);

	// crc and escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= 16'h0000;
			esc_pend_q <= 1'b0;
		end else if (accept) begin
			if (direction == DIR_ENCODE) begin
				crc_q      <= crc_next;
				esc_pend_q <= pend;
			end else begin
				crc_q      <= crc_base;
				esc_pend_q <= new_pend;
			end
		end
	end

	// checks
	`HCFC_ASSERT_NXT(a_pend_only_decode, !esc_pend_q, !esc_pend_q || $past(direction) == DIR_DECODE, "escape held in encode")
	`HCFC_ASSERT_IMP(a_encode_pushes, accept && direction == DIR_ENCODE, push, "encode beat made no job")

endmodule

// ===== rtl/hcfc_queue.sv =====
// ----------------------------------------------------------------------------
// hcfc_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`include "hdlc_crc16_frame_codec_defines.svh"

module hcfc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hcfc_pkg::job_t      push_job,
	input  logic                pop,
	output hcfc_pkg::job_t      head_job,
	output hcfc_pkg::q_status_t q_status
);
	import hcfc_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_job       = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// checks
	`HCFC_ASSERT_IMP(a_no_push_full, push, !q_status.full, "push into full queue")
	`HCFC_ASSERT_IMP(a_no_pop_empty, pop, !q_status.empty, "pop from empty queue")

endmodule

// ===== rtl/hcfc_back.sv =====
// ----------------------------------------------------------------------------
// hcfc_back
// walks the head job segment by segment, one line byte per cycle while out_stall is low
// ----------------------------------------------------------------------------
`include "hdlc_crc16_frame_codec_defines.svh"

module hcfc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hcfc_pkg::job_t       head_job,
	input  hcfc_pkg::q_status_t  q_status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output hcfc_pkg::out_item_t  out_data
);
	import hcfc_pkg::*;

	phase_t              phase_q;
	phase_t              phase_d;
	logic                sub_q;
	logic                sub_d;
	logic                out_valid_q;
	out_item_t           out_q;
	logic [NUM_SEGS-1:0] present;
	phase_t              cur_seg;
	logic                later;
	logic [7:0]          seg_byte;
	logic                seg_esc;
	logic                special;
	logic                seg_done;
	logic                is_last;
	logic                fire;
	logic [7:0]          line_byte;

	assign present = {head_job.trailer, head_job.trailer, head_job.trailer,
		head_job.body_valid, head_job.pre_valid};

	// first present segment at or after the phase, and anything beyond it
	always_comb begin
		cur_seg = phase_q;
		later   = 1'b0;
		for (int i = NUM_SEGS - 1; i >= 0; i--) begin
			if (present[i] && (3'(i) >= phase_q)) begin
				cur_seg = phase_t'(3'(i));
			end
		end
		for (int j = 0; j < NUM_SEGS; j++) begin
			if (present[j] && (3'(j) > cur_seg)) begin
				later = 1'b1;
			end
		end
	end

	// byte of the current segment
	always_comb begin
		case (cur_seg)
			PH_PRE: begin
				seg_byte = head_job.pre_byte;
				seg_esc  = 1'b0;
			end
			PH_BODY: begin
				seg_byte = head_job.body;
				seg_esc  = head_job.body_esc;
			end
			PH_CRC_LO: begin
				seg_byte = head_job.crc[7:0];
				seg_esc  = 1'b1;
			end
			PH_CRC_HI: begin
				seg_byte = head_job.crc[15:8];
				seg_esc  = 1'b1;
			end
			PH_FLAG: begin
				seg_byte = FLAG_BYTE;
				seg_esc  = 1'b0;
			end
			default: begin
				seg_byte = FLAG_BYTE;
				seg_esc  = 1'b0;
			end
		endcase
	end

	// an escape pair is 0x7D followed by the byte with bit 5 flipped
	assign special   = seg_esc && (seg_byte == FLAG_BYTE || seg_byte == ESC_BYTE);
	assign line_byte = special ? (sub_q ? (seg_byte ^ ESC_XOR) : ESC_BYTE) : seg_byte;
	assign seg_done  = !special || sub_q;
	assign is_last   = seg_done && !later;
	assign fire      = !q_status.empty && (!out_valid_q || !out_stall);
	assign pop       = fire && is_last;

	// next phase
	always_comb begin
		phase_d = phase_q;
		sub_d   = sub_q;
		if (fire) begin
			if (is_last) begin
				phase_d = PH_PRE;
				sub_d   = 1'b0;
			end else if (seg_done) begin
				sub_d = 1'b0;
				case (cur_seg)
					PH_PRE:    phase_d = PH_BODY;
					PH_BODY:   phase_d = PH_CRC_LO;
					PH_CRC_LO: phase_d = PH_CRC_HI;
					PH_CRC_HI: phase_d = PH_FLAG;
					default:   phase_d = PH_PRE;
				endcase
			end else begin
				sub_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE;
			sub_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			sub_q   <= sub_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fire || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.out_byte  <= line_byte;
			out_q.run_last  <= is_last;
			out_q.frame_end <= is_last && head_job.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`HCFC_ASSERT_IMP(a_sub_after_esc, sub_q, out_q.out_byte == ESC_BYTE, "escape pair lost its lead byte")
	`HCFC_ASSERT_IMP(a_end_is_last, out_valid_q && out_q.frame_end, out_q.run_last, "frame end not on last byte")

endmodule

// ===== rtl/hdlc_crc16_frame_codec.sv =====
// ----------------------------------------------------------------------------
// hdlc_crc16_frame_codec
// hdlc byte-stuffing framer and deframer with crc-16 (0x1021, init 0)
// ----------------------------------------------------------------------------
// The output side sends one line byte per clock cycle while it has jobs and
// out_stall is low. An input beat causes one line byte for a plain payload
// byte, two for an escaped byte, up to eight for a one-byte encoded frame
// (flag, escaped byte, escaped crc low and high, flag). A decode beat with a
// 0x7D that is not a last byte and follows no held escape causes none. The
// front end takes an input beat every cycle while the four-entry job queue
// has room, so input stalls only when escapes, frame ends or receiver stalls
// fill the queue. The user must write direction (paddr 0) only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module hdlc_crc16_frame_codec (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hcfc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// input beats
	input  logic                          in_valid,
	output logic                          in_stall,
	input  hcfc_pkg::in_item_t            in_data,
	// output beats
	output logic                          out_valid,
	input  logic                          out_stall,
	output hcfc_pkg::out_item_t           out_data
);
	import hcfc_pkg::*;

	logic      direction_q;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      head_job;
	q_status_t q_status;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, direction_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION) begin
			direction_q <= pwdata[0];
		end
	end

	// classify
	hcfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.direction(direction_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_status (q_status),
		.push     (push),
		.push_job (push_job)
	);

	// job queue
	hcfc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head_job(head_job),
		.q_status(q_status)
	);

	// emit
	hcfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_status (q_status),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== test/hcfc_checker.sv =====
// ----------------------------------------------------------------------------
// hcfc_checker
// watches the input and output channels of the frame codec, keeps its own
// copy of the encoder and decoder state, works out the line bytes that each
// input beat must cause and compares every output beat with the oldest one
// ----------------------------------------------------------------------------
module hcfc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hcfc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	input  logic [31:0]                   prdata,
	input  logic                          pready,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  hcfc_pkg::in_item_t            in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  hcfc_pkg::out_item_t           out_data,
	output int                            n_fail,
	output int                            n_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import hcfc_pkg::*;

	localparam logic [PADDR_W-1:0] DIRECTION_ADDR = {REG_DIRECTION, 2'b00};
	localparam int                 REPORT_LIMIT   = 10;

	// shadow of the block's register and state
	logic        dir;
	logic [15:0] crc_acc;
	logic        esc_held;

	// line bytes still owed by the block, oldest first
	out_item_t   pending_line_bytes[$];
	// line bytes caused by the beat being predicted
	out_item_t   burst[$];

	// crc-16, polynomial 0x1021, msb first
	function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic void add_byte(logic [7:0] b);
		out_item_t o;
		o.out_byte  = b;
		o.run_last  = 1'b0;
		o.frame_end = 1'b0;
		burst.push_back(o);
	endfunction

	// flag and escape bytes go out as 0x7D and the byte xor 0x20
	function automatic void add_stuffed(logic [7:0] b);
		if (b == FLAG_BYTE) begin
			add_byte(ESC_BYTE);
			add_byte(ESC_FLAG);
		end else if (b == ESC_BYTE) begin
			add_byte(ESC_BYTE);
			add_byte(ESC_ESC);
		end else begin
			add_byte(b);
		end
	endfunction

	function automatic void predict_line_bytes(in_item_t it);
		logic held_done;
		burst.delete();
		held_done = 1'b0;
		if (it.first_byte) begin
			crc_acc  = 16'h0000;
			esc_held = 1'b0;
		end
		if (dir == DIR_ENCODE) begin
			// opening flag, stuffed payload, crc low then high, closing flag
			if (it.first_byte)
				add_byte(FLAG_BYTE);
			crc_acc = crc16_next(crc_acc, it.data_byte);
			add_stuffed(it.data_byte);
			if (it.last_byte) begin
				add_stuffed(crc_acc[7:0]);
				add_stuffed(crc_acc[15:8]);
				add_byte(FLAG_BYTE);
				burst[burst.size()-1].frame_end = 1'b1;
			end
		end else begin
			// a held escape either completes or goes out unchanged
			if (esc_held) begin
				esc_held = 1'b0;
				if (it.data_byte == ESC_FLAG) begin
					add_byte(FLAG_BYTE);
					held_done = 1'b1;
				end else if (it.data_byte == ESC_ESC) begin
					add_byte(ESC_BYTE);
					held_done = 1'b1;
				end else begin
					add_byte(ESC_BYTE);
				end
			end
			if (!held_done) begin
				if (it.data_byte == ESC_BYTE && !it.last_byte)
					esc_held = 1'b1;
				else
					add_byte(it.data_byte);
			end
			if (it.last_byte && burst.size() > 0)
				burst[burst.size()-1].frame_end = 1'b1;
		end
		if (burst.size() > 0)
			burst[burst.size()-1].run_last = 1'b1;
		foreach (burst[i])
			pending_line_bytes.push_back(burst[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir       = DIR_ENCODE;
			crc_acc   = 16'h0000;
			esc_held  = 1'b0;
			n_fail    = 0;
			n_pending = 0;
			pending_line_bytes.delete();
		end else begin
			// register writes and read-back
			if (psel && penable && pready && paddr == DIRECTION_ADDR) begin
				if (pwrite) begin
					dir = pwdata[0];
				end else if (prdata[0] !== dir) begin
					n_fail++;
					if (n_fail <= REPORT_LIMIT)
						$display("hcfc_checker: direction read back %0b, expected %0b",
							prdata[0], dir);
				end
			end
			// output beat against the oldest owed line byte
			if (out_valid && !out_stall) begin
				if (pending_line_bytes.size() == 0) begin
					n_fail++;
					if (n_fail <= REPORT_LIMIT)
						$display("hcfc_checker: unexpected beat %02h %0b %0b",
							out_data.out_byte, out_data.run_last, out_data.frame_end);
				end else begin
					out_item_t want;
					want = pending_line_bytes.pop_front();
					if (out_data !== want) begin
						n_fail++;
						if (n_fail <= REPORT_LIMIT)
							$display("hcfc_checker: mismatch, expected %02h/%0b/%0b got %02h/%0b/%0b",
								want.out_byte, want.run_last, want.frame_end,
								out_data.out_byte, out_data.run_last, out_data.frame_end);
					end
				end
			end
			// input beat
			if (in_valid && !in_stall)
				predict_line_bytes(in_data);
			n_pending = pending_line_bytes.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives the hdlc crc-16 frame codec in both directions: a directed set of
// frames and escape corner cases, then random frames under several patterns
// of sender gaps and receiver stalls; hcfc_checker predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hcfc_pkg::*;

	localparam logic [PADDR_W-1:0] DIRECTION_ADDR = {REG_DIRECTION, 2'b00};
	localparam int DRAIN_CYCLES = 64;
	localparam int QUIET_LIMIT  = 4000;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_BEATS  = 60;

	typedef logic [7:0] line_bytes_t[$];

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;

	int n_fail;
	int n_pending;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int quiet_cycles = 0;
	int phase_beats  = 0;

	hdlc_crc16_frame_codec u_top (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data
	);

	hcfc_checker u_checker (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.n_fail, .n_pending
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one input beat, with random gaps in front of it
	task automatic send_beat(input logic [7:0] b, input logic is_first, input logic is_last);
		in_item_t item;
		bit       took;
		item.data_byte  = b;
		item.first_byte = is_first;
		item.last_byte  = is_last;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		phase_beats++;
	endtask

	task automatic send_frame(input line_bytes_t line);
		foreach (line[i])
			send_beat(line[i], i == 0, i == line.size() - 1);
	endtask

	// payload bytes weighted towards the flag and escape codes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			2: return ($urandom_range(1) == 1) ? ESC_FLAG : ESC_ESC;
			default: return 8'($urandom);
		endcase
	endfunction

	// encode: raw payload; decode: a stuffed line frame, sometimes broken
	task automatic send_random_frame(input logic mode);
		line_bytes_t line;
		logic [7:0]  raw;
		int          len;
		len = ($urandom_range(7) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
		if (mode == DIR_DECODE)
			line.push_back(FLAG_BYTE);
		for (int i = 0; i < len; i++) begin
			raw = pick_byte();
			if (mode == DIR_ENCODE) begin
				line.push_back(raw);
			end else if ($urandom_range(7) == 0) begin
				// escape followed by whatever comes
				line.push_back(ESC_BYTE);
				line.push_back(raw);
			end else if (raw == FLAG_BYTE || raw == ESC_BYTE) begin
				line.push_back(ESC_BYTE);
				line.push_back(raw ^ ESC_XOR);
			end else begin
				line.push_back(raw);
			end
		end
		if (mode == DIR_DECODE)
			line.push_back(($urandom_range(5) == 0) ? ESC_BYTE : FLAG_BYTE);
		send_frame(line);
	endtask

	// wait for every owed byte, then for any beat still in flight
	task automatic drain_block();
		in_valid <= 1'b0;
		do @(negedge clk); while (n_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup phase, access phase until pready, then idle
	task automatic apb_access(input logic wr, input logic [31:0] wdata);
		bit done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= DIRECTION_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_direction(input logic d);
		drain_block();
		apb_access(1'b1, {31'b0, d});
		apb_access(1'b0, 32'h0);
	endtask

	initial begin
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encode corner cases
		set_direction(DIR_ENCODE);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b0);
		send_beat(FLAG_BYTE, 1'b0, 1'b0);
		send_beat(ESC_BYTE, 1'b0, 1'b0);
		send_beat(ESC_FLAG, 1'b0, 1'b0);
		send_beat(ESC_ESC, 1'b0, 1'b1);
		// bytes after the frame end, with no new frame start
		send_beat(8'h12, 1'b0, 1'b0);
		send_beat(8'h34, 1'b0, 1'b1);
		send_beat(FLAG_BYTE, 1'b1, 1'b1);

		// decode corner cases
		set_direction(DIR_DECODE);
		send_beat(FLAG_BYTE, 1'b1, 1'b0);
		send_beat(ESC_BYTE, 1'b0, 1'b0);
		send_beat(ESC_FLAG, 1'b0, 1'b0);
		send_beat(ESC_BYTE, 1'b0, 1'b0);
		send_beat(ESC_ESC, 1'b0, 1'b0);
		// unmatched escape
		send_beat(ESC_BYTE, 1'b0, 1'b0);
		send_beat(8'h41, 1'b0, 1'b0);
		// escapes in a row, the last one at frame end
		send_beat(ESC_BYTE, 1'b0, 1'b0);
		send_beat(ESC_BYTE, 1'b0, 1'b0);
		send_beat(ESC_BYTE, 1'b0, 1'b1);
		// held escape dropped by a frame start
		send_beat(ESC_BYTE, 1'b0, 1'b0);
		send_beat(ESC_BYTE, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b0, 1'b1);
		// lone escape on the last byte
		send_beat(ESC_BYTE, 1'b0, 1'b1);
		// escape left held going into encode
		send_beat(ESC_BYTE, 1'b0, 1'b0);

		// random frames, both directions under each idling pattern
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_direction((ph % 2 == 1) ? DIR_DECODE : DIR_ENCODE);
			case (ph / 2)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 81;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 81;
				end
				default: begin
					idle_pct  = 35;
					stall_pct = 35;
				end
			endcase
			phase_beats = 0;
			while (phase_beats < PHASE_BEATS) begin
				if ($urandom_range(9) == 0)
					send_beat(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
				else
					send_random_frame((ph % 2 == 1) ? DIR_DECODE : DIR_ENCODE);
			end
		end

		drain_block();
		if (n_fail == 0 && n_pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hcfc_pkg.sv
rtl/hcfc_front.sv
rtl/hcfc_queue.sv
rtl/hcfc_back.sv
rtl/hdlc_crc16_frame_codec.sv
test/hcfc_checker.sv
test/tb_top.sv
